FILE: src/pirp_pkg.sv
// ----------------------------------------------------------------------------
// pirp_pkg
// types, codes and the name character map shared by the reply parser
// ----------------------------------------------------------------------------
package pirp_pkg;

    // one received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic [2:0]  item_kind;
        logic [31:0] item_value;
        logic [1:0]  status;
        logic        last_result;
    } t_out_item;

    // parse phase of the current packet
    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_PLAYER = 4'd1,
        PH_NAME   = 4'd2,
        PH_COLORS = 4'd3,
        PH_RES1   = 4'd4,
        PH_RES2   = 4'd5,
        PH_RES3   = 4'd6,
        PH_FRAGS  = 4'd7,
        PH_CONN   = 4'd8,
        PH_ADDR   = 4'd9,
        PH_DONE   = 4'd10
    } t_phase;

    // result kinds
    localparam logic [2:0] KIND_PLAYER  = 3'd0;
    localparam logic [2:0] KIND_NAME    = 3'd1;
    localparam logic [2:0] KIND_COLORS  = 3'd2;
    localparam logic [2:0] KIND_RSVD    = 3'd3;
    localparam logic [2:0] KIND_FRAGS   = 3'd4;
    localparam logic [2:0] KIND_CONN    = 3'd5;
    localparam logic [2:0] KIND_ADDR    = 3'd6;
    localparam logic [2:0] KIND_STATUS  = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [1:0] ST_LENGTH    = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // header bytes
    localparam logic [7:0] HDR_CTRL     = 8'h80;
    localparam logic [7:0] HDR_ZERO     = 8'h00;
    localparam logic [7:0] HDR_REPLY    = 8'h84;

    localparam int unsigned COUNT_W     = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // queue between parser front and result back end
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // work record handed from front to back
    typedef struct packed {
        logic        item_vld;
        logic [2:0]  kind;
        logic [31:0] value;
        logic        st_vld;
        logic [1:0]  st;
    } t_rec;

    typedef struct packed {
        logic       ok;
        logic [6:0] ch;
    } t_map;

    // decorative name byte to readable char, ok low when the byte is dropped
    function automatic t_map map_name_char(input logic [7:0] b);
        t_map m;
        logic [7:0] v;
        m.ok = 1'b1;
        v    = 8'd0;
        if (b >= 8'd32 && b <= 8'd126) begin
            v = b;
        end else if (b >= 8'd160 && b <= 8'd254) begin
            v = b - 8'd128;
        end else if (b >= 8'd146 && b <= 8'd155) begin
            v = b - 8'd98;
        end else if (b >= 8'd18 && b <= 8'd27) begin
            v = b + 8'd30;
        end else if ((b >= 8'd6 && b <= 8'd9) || (b >= 8'd1 && b <= 8'd4) ||
                     (b >= 8'd134 && b <= 8'd137)) begin
            v = 8'd35;
        end else if (b == 8'd5 || b == 8'd14 || b == 8'd15 || b == 8'd28 ||
                     b == 8'd133 || b == 8'd142 || b == 8'd143) begin
            v = 8'h2E;
        end else if (b == 8'd128 || b == 8'd144 || b == 8'd157) begin
            v = 8'h5B;
        end else if (b == 8'd129 || b == 8'd158) begin
            v = 8'h3D;
        end else if (b == 8'd130 || b == 8'd145 || b == 8'd159) begin
            v = 8'h5D;
        end else begin
            m.ok = 1'b0;
        end
        m.ch = v[6:0];
        return m;
    endfunction

endpackage

FILE: src/pirp_front.sv
// ----------------------------------------------------------------------------
// pirp_front
// byte parser: walks the packet layout and turns each byte into a work record
// ----------------------------------------------------------------------------
module pirp_front #(
    parameter int unsigned MAX_PACKET = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  pirp_pkg::t_in_item i_item,
    output logic              o_rec_wr,
    output pirp_pkg::t_rec    o_rec
);
    import pirp_pkg::*;

    localparam logic [COUNT_W:0] MAX_CNT = (COUNT_W+1)'(MAX_PACKET);

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_bc, n_bc;
    logic               r_hg, n_hg;
    logic [15:0]        r_dl, n_dl;
    logic [23:0]        r_acc, n_acc;
    logic [1:0]         r_idx, n_idx;
    logic               r_ns, n_ns;
    logic               r_ovr, n_ovr;

    logic [7:0]         b;
    logic               parse;
    t_map               nm;
    logic               hg_tmp;
    t_rec               rec;

    assign b     = i_item.data_byte;
    assign parse = {1'b0, r_bc} < MAX_CNT;
    assign nm    = map_name_char(b);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_hg    = r_hg;
        n_dl    = r_dl;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_ns    = r_ns;
        n_ovr   = r_ovr;
        hg_tmp  = r_hg;
        if (!parse) begin
            n_ovr = 1'b1;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_bc == COUNT_W'(0) && b != HDR_CTRL) n_hg = 1'b0;
                    if (r_bc == COUNT_W'(1) && b != HDR_ZERO) n_hg = 1'b0;
                    if (r_bc == COUNT_W'(2)) n_dl = {b, r_dl[7:0]};
                    if (r_bc == COUNT_W'(3)) n_dl = {r_dl[15:8], b};
                    if (r_bc == COUNT_W'(4)) begin
                        hg_tmp  = r_hg && (b == HDR_REPLY);
                        n_hg    = hg_tmp;
                        n_phase = hg_tmp ? PH_PLAYER : PH_DONE;
                    end
                end
                PH_PLAYER: n_phase = PH_NAME;
                PH_NAME: begin
                    if (b == 8'd0) n_phase = PH_COLORS;
                    else if (nm.ok) n_ns = 1'b1;
                end
                PH_COLORS: n_phase = PH_RES1;
                PH_RES1:   n_phase = PH_RES2;
                PH_RES2:   n_phase = PH_RES3;
                PH_RES3:   n_phase = PH_FRAGS;
                PH_FRAGS, PH_CONN: begin
                    if (r_idx == 2'd3) begin
                        n_idx   = 2'd0;
                        n_acc   = '0;
                        n_phase = (r_phase == PH_FRAGS) ? PH_CONN : PH_ADDR;
                    end else begin
                        n_idx = r_idx + 2'd1;
                        case (r_idx)
                            2'd0:    n_acc[7:0]   = b;
                            2'd1:    n_acc[15:8]  = b;
                            default: n_acc[23:16] = b;
                        endcase
                    end
                end
                PH_ADDR: if (b == 8'd0) n_phase = PH_DONE;
                default: ;
            endcase
        end
        if (r_bc != COUNT_MAX) n_bc = r_bc + COUNT_W'(1);
    end

    // record for this byte
    always_comb begin
        rec = '0;
        if (parse) begin
            unique case (r_phase)
                PH_PLAYER: begin
                    rec.item_vld = 1'b1;
                    rec.kind     = KIND_PLAYER;
                    rec.value    = {24'd0, b};
                end
                PH_NAME: begin
                    if (b != 8'd0 && nm.ok) begin
                        rec.item_vld = 1'b1;
                        rec.kind     = KIND_NAME;
                        rec.value    = {25'd0, nm.ch};
                    end
                end
                PH_COLORS: begin
                    rec.item_vld = 1'b1;
                    rec.kind     = KIND_COLORS;
                    rec.value    = {24'd0, b};
                end
                PH_RES1, PH_RES2, PH_RES3: begin
                    rec.item_vld = 1'b1;
                    rec.kind     = KIND_RSVD;
                    rec.value    = {24'd0, b};
                end
                PH_FRAGS, PH_CONN: begin
                    if (r_idx == 2'd3) begin
                        rec.item_vld = 1'b1;
                        rec.kind     = (r_phase == PH_FRAGS) ? KIND_FRAGS : KIND_CONN;
                        rec.value    = {b, r_acc};
                    end
                end
                PH_ADDR: begin
                    if (b != 8'd0) begin
                        rec.item_vld = 1'b1;
                        rec.kind     = KIND_ADDR;
                        rec.value    = {24'd0, b};
                    end
                end
                default: ;
            endcase
        end
        if (i_item.last_byte) begin
            rec.st_vld = 1'b1;
            if (!n_hg || n_phase == PH_HEADER) begin
                rec.st = ST_BAD_HDR;
            end else if (n_ovr || n_phase != PH_DONE || n_dl != {5'd0, n_bc}) begin
                rec.st = ST_LENGTH;
            end else if (!n_ns) begin
                rec.st = ST_EMPTY;
            end else begin
                rec.st = ST_OK;
            end
        end
    end

    assign o_rec    = rec;
    assign o_rec_wr = i_acc && (rec.item_vld || rec.st_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_item.last_byte)) begin
            r_phase <= PH_HEADER;
            r_bc    <= '0;
            r_hg    <= 1'b1;
            r_dl    <= '0;
            r_acc   <= '0;
            r_idx   <= '0;
            r_ns    <= 1'b0;
            r_ovr   <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_hg    <= n_hg;
            r_dl    <= n_dl;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_ns    <= n_ns;
            r_ovr   <= n_ovr;
        end
    end

endmodule

FILE: src/pirp_fifo.sv
// ----------------------------------------------------------------------------
// pirp_fifo
// short record queue between the parser front and the result back end
// ----------------------------------------------------------------------------
module pirp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  pirp_pkg::t_rec i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output pirp_pkg::t_rec o_rdata,
    output logic           o_empty
);
    import pirp_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              wr_en, rd_en;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + QPTR_W'(1);
            if (rd_en) r_rp <= r_rp + QPTR_W'(1);
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/pirp_back.sv
// ----------------------------------------------------------------------------
// pirp_back
// expands records into result beats and holds them in the output register
// ----------------------------------------------------------------------------
module pirp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pirp_pkg::t_rec      i_rec,
    input  logic                i_rec_empty,
    output logic                o_rec_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output pirp_pkg::t_out_item o_result
);
    import pirp_pkg::*;

    logic      r_vld, n_vld;
    logic      r_half, n_half;
    t_out_item r_out, n_out;
    logic      load, emit_item;

    assign load      = !i_rec_empty && (!r_vld || i_pop);
    assign emit_item = i_rec.item_vld && !r_half;

    always_comb begin
        n_vld    = r_vld;
        n_half   = r_half;
        n_out    = r_out;
        o_rec_rd = 1'b0;
        if (i_pop && r_vld) n_vld = 1'b0;
        if (load) begin
            n_vld = 1'b1;
            if (emit_item) begin
                n_out.item_kind   = i_rec.kind;
                n_out.item_value  = i_rec.value;
                n_out.status      = ST_OK;
                n_out.last_result = 1'b0;
                // status still owed: keep the record for one more beat
                if (i_rec.st_vld) begin
                    n_half = 1'b1;
                end else begin
                    o_rec_rd = 1'b1;
                end
            end else begin
                n_out.item_kind   = KIND_STATUS;
                n_out.item_value  = '0;
                n_out.status      = i_rec.st;
                n_out.last_result = 1'b1;
                n_half            = 1'b0;
                o_rec_rd          = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_half <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_half <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_vld;
    assign o_result = r_out;

endmodule

FILE: src/player_info_reply_parser.sv
// ----------------------------------------------------------------------------
// player_info_reply_parser
// parses a player-info reply byte stream into player fields and a status beat
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------
//  bytes    in         push / full          i_item   (data_byte, last_byte)
//  results  out        empty / pop          o_result (item_kind, item_value,
//                                                     status, last_result)
//
//  one byte beat is taken per cycle while full is low; a byte's result beat
//  passes through front decode, the record queue and then the output
//  register in the back end
//  the last byte of a packet can owe two result beats (a body item and the
//  status), which the back end drains one after the other from one queue record
//  full rises only when the four-entry record queue fills, so a stalled
//  consumer backs up into the byte side after a few beats
//  synchronous active-low reset returns the parser to the header phase and
//  empties the queue and output register; no clearing pass is needed
//
module player_info_reply_parser #(
    parameter int unsigned MAX_PACKET = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  pirp_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output pirp_pkg::t_out_item o_result
);
    import pirp_pkg::*;

    logic acc;
    logic rec_wr, rec_rd, rec_empty;
    t_rec rec_in, rec_head;

    // a byte is taken whenever the queue has room for its record
    assign acc = push && !full;

    // front: header checks, length tracking, field walk, name mapping
    pirp_front #(
        .MAX_PACKET(MAX_PACKET)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_item   (i_item),
        .o_rec_wr (rec_wr),
        .o_rec    (rec_in)
    );

    // decouples the parser from result stalls
    pirp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_wr),
        .i_wdata (rec_in),
        .o_full  (full),
        .i_rd    (rec_rd),
        .o_rdata (rec_head),
        .o_empty (rec_empty)
    );

    // back: one or two result beats per record, registered
    pirp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_head),
        .i_rec_empty (rec_empty),
        .o_rec_rd    (rec_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

FILE: bench/player_info_reply_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// player_info_reply_parser_test
// self-checking bench for the player-info reply parser
// ----------------------------------------------------------------------------
// whole packets go in one byte beat at a time. A local parse model predicts
// every result beat, and each popped beat is checked field by field against
// the oldest prediction. Directed packets cover header faults, length and
// truncation faults, empty names, trailing bytes and the packet size limit.
// Random packets, mostly well formed with random content, run under three
// idling mixes on the byte and result sides.
// ----------------------------------------------------------------------------
module player_info_reply_parser_test;
    import pirp_pkg::*;

    localparam int MAX_PKT    = 1024;
    localparam int CLK_HIGH   = 6;
    localparam int CLK_LOW    = 6;
    localparam int DRAIN_WAIT = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    player_info_reply_parser #(
        .MAX_PACKET(MAX_PKT)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // idle odds in percent, changed between test phases
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // predicted result beats, oldest first
    t_out_item parsed_items_q[$];

    int fail_count    = 0;
    int beats_checked = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    int status_count[4];

    // parse model state
    logic [10:0] rx_count;
    t_phase      rx_phase;
    logic        hdr_ok;
    logic [15:0] decl_len;
    logic [31:0] word_acc;
    logic [1:0]  word_idx;
    logic        name_seen;
    logic        overrun;

    // packet under construction
    logic [7:0] pkt[$];

    task automatic clear_packet_state();
        rx_count  = '0;
        rx_phase  = PH_HEADER;
        hdr_ok    = 1'b1;
        decl_len  = '0;
        word_acc  = '0;
        word_idx  = '0;
        name_seen = 1'b0;
        overrun   = 1'b0;
    endtask

    // decorative name byte to readable char, -1 when dropped
    function automatic int readable_char(input logic [7:0] b);
        int v;
        v = int'(b);
        if (v >= 32 && v <= 126) return v;
        if (v >= 160 && v <= 254) return v - 128;
        if (v >= 146 && v <= 155) return v - 98;
        if (v >= 18 && v <= 27) return v + 30;
        if ((v >= 1 && v <= 4) || (v >= 6 && v <= 9) || (v >= 134 && v <= 137)) return 35;
        case (v)
            5, 14, 15, 28, 133, 142, 143: return 46;
            128, 144, 157:                return 91;
            129, 158:                     return 61;
            130, 145, 159:                return 93;
            default:                      return -1;
        endcase
    endfunction

    function automatic t_out_item make_beat(input logic [2:0] kind, input logic [31:0] value,
                                            input logic [1:0] st, input logic lst);
        t_out_item r;
        r.item_kind   = kind;
        r.item_value  = value;
        r.status      = st;
        r.last_result = lst;
        return r;
    endfunction

    // advance the parse model by one accepted byte and queue what it yields
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        int         ch;
        logic [1:0] st;
        if (rx_count >= MAX_PKT) begin
            overrun = 1'b1;
        end else begin
            case (rx_phase)
                PH_HEADER: begin
                    if (rx_count == 0 && b != HDR_CTRL) hdr_ok = 1'b0;
                    if (rx_count == 1 && b != HDR_ZERO) hdr_ok = 1'b0;
                    if (rx_count == 2) decl_len[15:8] = b;
                    if (rx_count == 3) decl_len[7:0] = b;
                    if (rx_count == 4) begin
                        if (b != HDR_REPLY) hdr_ok = 1'b0;
                        rx_phase = hdr_ok ? PH_PLAYER : PH_DONE;
                    end
                end
                PH_PLAYER: begin
                    parsed_items_q.push_back(make_beat(KIND_PLAYER, 32'(b), ST_OK, 1'b0));
                    rx_phase = PH_NAME;
                end
                PH_NAME: begin
                    if (b == 8'd0) begin
                        rx_phase = PH_COLORS;
                    end else begin
                        ch = readable_char(b);
                        if (ch >= 0) begin
                            parsed_items_q.push_back(make_beat(KIND_NAME, 32'(ch), ST_OK, 1'b0));
                            name_seen = 1'b1;
                        end
                    end
                end
                PH_COLORS: begin
                    parsed_items_q.push_back(make_beat(KIND_COLORS, 32'(b), ST_OK, 1'b0));
                    rx_phase = PH_RES1;
                end
                PH_RES1, PH_RES2, PH_RES3: begin
                    parsed_items_q.push_back(make_beat(KIND_RSVD, 32'(b), ST_OK, 1'b0));
                    rx_phase = t_phase'(rx_phase + 4'd1);
                end
                PH_FRAGS, PH_CONN: begin
                    // little-endian word, low byte first
                    word_acc = word_acc | (32'(b) << (8 * word_idx));
                    if (word_idx == 2'd3) begin
                        parsed_items_q.push_back(make_beat(
                            (rx_phase == PH_FRAGS) ? KIND_FRAGS : KIND_CONN,
                            word_acc, ST_OK, 1'b0));
                        word_acc = '0;
                        word_idx = '0;
                        rx_phase = t_phase'(rx_phase + 4'd1);
                    end else begin
                        word_idx = word_idx + 2'd1;
                    end
                end
                PH_ADDR: begin
                    if (b == 8'd0) rx_phase = PH_DONE;
                    else parsed_items_q.push_back(make_beat(KIND_ADDR, 32'(b), ST_OK, 1'b0));
                end
                default: ;
            endcase
        end
        if (rx_count != COUNT_MAX) rx_count = rx_count + 11'd1;

        if (lst) begin
            if (!hdr_ok || rx_phase == PH_HEADER) st = ST_BAD_HDR;
            else if (overrun || rx_phase != PH_DONE || {5'd0, rx_count} != decl_len)
                st = ST_LENGTH;
            else if (!name_seen) st = ST_EMPTY;
            else st = ST_OK;
            parsed_items_q.push_back(make_beat(KIND_STATUS, 32'd0, st, 1'b1));
            status_count[st]++;
            clear_packet_state();
        end
    endtask

    // entered at a falling edge, returns at the falling edge after the beat
    task automatic push_byte(input logic [7:0] b, input logic lst);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = lst;
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(b, lst);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic stream_pkt();
        for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // declared length follows the actual size, where the header is long enough
    task automatic fix_len();
        logic [15:0] n;
        n = 16'(pkt.size());
        if (pkt.size() > 2) pkt[2] = n[15:8];
        if (pkt.size() > 3) pkt[3] = n[7:0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // well-formed packet with random content
    task automatic build_good(input int name_len, input int addr_len, input int tail_len);
        logic [31:0] w;
        pkt.delete();
        pkt.push_back(HDR_CTRL);
        pkt.push_back(HDR_ZERO);
        pkt.push_back(8'd0);
        pkt.push_back(8'd0);
        pkt.push_back(HDR_REPLY);
        pkt.push_back(8'($urandom_range(255)));
        repeat (name_len) pkt.push_back(8'($urandom_range(255, 1)));
        pkt.push_back(8'd0);
        repeat (4) pkt.push_back(8'($urandom_range(255)));    // colors, reserved
        repeat (2) begin
            w = rand_word();
            for (int i = 0; i < 4; i++) pkt.push_back(w[8*i +: 8]);
        end
        repeat (addr_len) pkt.push_back(8'($urandom_range(255, 1)));
        pkt.push_back(8'd0);
        repeat (tail_len) pkt.push_back(8'($urandom_range(255)));
        fix_len();
    endtask

    // result side: pop at random, check every popped beat
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin : compare_parsed
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (parsed_items_q.size() == 0) begin
                $error("beat with none predicted: kind %0d value %0h",
                       o_result.item_kind, o_result.item_value);
                fail_count++;
            end else begin
                want = parsed_items_q.pop_front();
                beats_checked++;
                if (o_result.item_kind !== want.item_kind) begin
                    $error("item_kind expected %0d actual %0d",
                           want.item_kind, o_result.item_kind);
                    fail_count++;
                end
                if (o_result.item_value !== want.item_value) begin
                    $error("item_value expected %0h actual %0h",
                           want.item_value, o_result.item_value);
                    fail_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.last_result !== want.last_result) begin
                    $error("last_result expected %0d actual %0d",
                           want.last_result, o_result.last_result);
                    fail_count++;
                end
            end
        end
    end

    // extremes of every field in one good packet
    task automatic test_field_extremes();
        pkt = '{HDR_CTRL, HDR_ZERO, 8'h00, 8'h00, HDR_REPLY,
                8'hFF,                                  // player
                8'h01, 8'hA0, 8'hFE, 8'h00,             // name, terminator
                8'h00, 8'hFF, 8'h00, 8'h80,             // colors, reserved
                8'hFF, 8'hFF, 8'hFF, 8'hFF,             // frags
                8'h00, 8'h00, 8'h00, 8'h00,             // connect time
                8'hFF, 8'h01, 8'h00};                   // address, terminator
        fix_len();
        stream_pkt();
    endtask

    task automatic test_bad_header();
        // ends on the first byte
        pkt = '{HDR_CTRL};
        stream_pkt();
        // ends before the reply code
        pkt = '{HDR_CTRL, HDR_ZERO, 8'h00, 8'h04};
        stream_pkt();
        build_good(2, 1, 0);
        pkt[0] = 8'h00;
        stream_pkt();
        build_good(2, 1, 0);
        pkt[1] = HDR_CTRL;
        stream_pkt();
        build_good(2, 1, 0);
        pkt[4] = 8'h04;
        stream_pkt();
    endtask

    task automatic test_length_and_truncation();
        build_good(2, 2, 1);
        pkt[3] = pkt[3] + 8'd1;
        stream_pkt();
        build_good(2, 2, 0);
        pkt[2] = 8'hFF;
        stream_pkt();
        // address terminator missing
        build_good(3, 3, 0);
        void'(pkt.pop_back());
        fix_len();
        stream_pkt();
        // stops three bytes into the frags word
        build_good(3, 3, 0);
        while (pkt.size() > 17) void'(pkt.pop_back());
        fix_len();
        stream_pkt();
    endtask

    task automatic test_empty_name();
        build_good(0, 2, 0);
        stream_pkt();
        // name bytes that map to nothing
        build_good(2, 2, 0);
        pkt[6] = 8'h0A;
        pkt[7] = 8'hFF;
        stream_pkt();
    endtask

    task automatic test_trailing_bytes();
        build_good(2, 2, 3);
        stream_pkt();
    endtask

    // one packet right at the size limit, one just past it
    task automatic test_packet_size_limit();
        build_good(4, 3, 0);
        while (pkt.size() < MAX_PKT) pkt.push_back(8'($urandom_range(255)));
        fix_len();
        stream_pkt();
        build_good(4, 3, 0);
        while (pkt.size() < MAX_PKT + 6) pkt.push_back(8'($urandom_range(255)));
        fix_len();
        stream_pkt();
    endtask

    task automatic rand_packet();
        int pick;
        int name_len;
        int idx;
        int keep;
        pick     = $urandom_range(99);
        name_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        build_good(name_len, $urandom_range(5), ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
        if (pick < 60) begin
            // well formed as built
        end else if (pick < 70) begin
            case ($urandom_range(2))
                0:       idx = 0;
                1:       idx = 1;
                default: idx = 4;
            endcase
            pkt[idx] = pkt[idx] ^ 8'($urandom_range(255, 1));
        end else if (pick < 80) begin
            keep = $urandom_range(pkt.size() - 1, 1);
            while (pkt.size() > keep) void'(pkt.pop_back());
            fix_len();
        end else if (pick < 90) begin
            pkt[2] = 8'($urandom_range(255));
            pkt[3] = 8'($urandom_range(255));
        end else begin
            pkt.delete();
            repeat ($urandom_range(10, 1)) pkt.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int n_bytes);
        int start;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        start             = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            rand_packet();
            stream_pkt();
        end
    endtask

    initial begin
        clear_packet_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 25;
        receiver_idle_pct = 80;
        test_field_extremes();
        test_bad_header();
        test_length_and_truncation();
        test_empty_name();
        test_trailing_bytes();
        test_random(25, 80, 185);
        test_random(80, 25, 185);
        test_packet_size_limit();
        test_random(0, 0, 185);
        push <= 1'b0;

        // let every predicted beat drain, then a short settle
        while (parsed_items_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d packets, %0d bytes, %0d result beats checked", packets_sent,
                 bytes_sent, beats_checked);
        $display("status ok %0d, bad header %0d, length %0d, empty name %0d",
                 status_count[ST_OK], status_count[ST_BAD_HDR], status_count[ST_LENGTH],
                 status_count[ST_EMPTY]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
